>>> rtl/core/median_filter_3x3_defines.svh
// Assertion macros used by the checker module of the median filter.
`ifndef MEDIAN_FILTER_3X3_DEFINES_SVH
`define MEDIAN_FILTER_3X3_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MF3X3_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MF3X3_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/mf3x3_pkg.sv
`timescale 1ns / 1ps

package mf3x3_pkg;

   localparam int PIX_W             = 8;
   localparam int CFG_W             = 13;
   localparam int ROW_W             = 12;
   localparam int ROW_LIMIT         = 4096;
   localparam int MIN_SIZE          = 3;
   localparam int MAX_WIDTH_DEFAULT = 4096;
   localparam int LINE_W            = 2 * PIX_W;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
   localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic emit;
      logic last;
   } pos_type;

   typedef struct packed {
      logic [PIX_W-1:0] lo;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] hi;
   } col_type;

   typedef struct packed {
      logic             valid;
      logic             last;
      logic [PIX_W-1:0] lo;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] hi;
   } med_part_type;

   function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
      return (a < b) ? b : a;
   endfunction

   function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   function automatic col_type sort3(input logic [PIX_W-1:0] a,
                                     input logic [PIX_W-1:0] b,
                                     input logic [PIX_W-1:0] c);
      logic [PIX_W-1:0] x;
      logic [PIX_W-1:0] y;
      logic [PIX_W-1:0] t;
      col_type          s;
      x     = min2(a, b);
      y     = max2(a, b);
      t     = max2(x, c);
      s.lo  = min2(x, c);
      s.mid = min2(y, t);
      s.hi  = max2(y, t);
      return s;
   endfunction

endpackage

>>> rtl/core/mf3x3_position.sv
`timescale 1ns / 1ps

module mf3x3_position
   import mf3x3_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic                         frame_start,
   input  logic [CFG_W-1:0]             width_cfg,
   input  logic [CFG_W-1:0]             height_cfg,
   output logic [$clog2(MAX_WIDTH)-1:0] addr,
   output pos_type                      pos
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int EW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

   logic [CW-1:0]    col_ff;
   logic [CW-1:0]    col_in;
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;
   logic [EW-1:0]    width_raw;
   logic [EW-1:0]    width_eff;
   logic [CFG_W-1:0] height_eff;
   logic [CW-1:0]    col_cur;
   logic [ROW_W-1:0] row_cur;
   logic [EW-1:0]    col_ext;
   logic [EW-1:0]    col_next;
   logic [CFG_W-1:0] row_ext;
   logic [CFG_W-1:0] row_next;

   always_comb begin
      width_raw = EW'(width_cfg);
      if (width_raw < EW'(MIN_SIZE)) begin
         width_eff = EW'(MIN_SIZE);
      end else if (width_raw > EW'(MAX_WIDTH)) begin
         width_eff = EW'(MAX_WIDTH);
      end else begin
         width_eff = width_raw;
      end

      if (height_cfg < CFG_W'(MIN_SIZE)) begin
         height_eff = CFG_W'(MIN_SIZE);
      end else if (height_cfg > CFG_W'(ROW_LIMIT)) begin
         height_eff = CFG_W'(ROW_LIMIT);
      end else begin
         height_eff = height_cfg;
      end

      col_cur  = frame_start ? '0 : col_ff;
      row_cur  = frame_start ? '0 : row_ff;
      col_ext  = EW'(col_cur);
      row_ext  = CFG_W'(row_cur);
      col_next = col_ext + EW'(1);
      row_next = row_ext + CFG_W'(1);

      addr     = col_cur;
      pos.emit = (row_ext >= CFG_W'(2)) && (row_ext < height_eff) &&
                 (col_ext >= EW'(2)) && (col_ext < width_eff);
      pos.last = (row_ext == height_eff - CFG_W'(1)) &&
                 (col_ext == width_eff - EW'(1));

      if (col_next >= width_eff) begin
         col_in = '0;
         row_in = (row_next >= height_eff) ? '0 : row_next[ROW_W-1:0];
      end else begin
         col_in = col_next[CW-1:0];
         row_in = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

>>> rtl/core/mf3x3_line_store.sv
`timescale 1ns / 1ps

module mf3x3_line_store
   import mf3x3_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         advance,
   input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
   input  logic                         wr_en,
   input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
   input  logic [LINE_W-1:0]            wr_data,
   output logic [LINE_W-1:0]            rd_data
);

   // Each entry holds the row two up in the upper byte and the row one up in the lower byte.
   logic [LINE_W-1:0] mem_ff [MAX_WIDTH];
   logic [LINE_W-1:0] rd_data_ff;
   logic              bypass_ff;
   logic [LINE_W-1:0] bypass_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (advance) begin
         rd_data_ff     <= mem_ff[rd_addr];
         bypass_ff      <= wr_en && (wr_addr == rd_addr);
         bypass_data_ff <= wr_data;
      end
   end

   assign rd_data = bypass_ff ? bypass_data_ff : rd_data_ff;

endmodule

>>> rtl/core/mf3x3_median.sv
`timescale 1ns / 1ps

module mf3x3_median
   import mf3x3_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             col_valid,
   input  pos_type          col_pos,
   input  logic [PIX_W-1:0] up_two,
   input  logic [PIX_W-1:0] up_one,
   input  logic [PIX_W-1:0] pixel,
   output med_part_type     part
);

   // The window keeps each of its three columns already sorted.
   col_type      win_ff [3];
   logic         s2_valid_ff;
   logic         s2_last_ff;
   med_part_type s3_ff;
   med_part_type s3_in;
   col_type      new_col;

   always_comb begin
      new_col     = sort3(up_two, up_one, pixel);
      s3_in.valid = s2_valid_ff;
      s3_in.last  = s2_last_ff;
      s3_in.lo    = max2(max2(win_ff[0].lo, win_ff[1].lo), win_ff[2].lo);
      s3_in.mid   = med3(win_ff[0].mid, win_ff[1].mid, win_ff[2].mid);
      s3_in.hi    = min2(min2(win_ff[0].hi, win_ff[1].hi), win_ff[2].hi);
   end

   always_ff @(posedge clock) begin
      if (advance && col_valid) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= new_col;
      end
      if (advance) begin
         s2_last_ff <= col_pos.last;
         s3_ff.last <= s3_in.last;
         s3_ff.lo   <= s3_in.lo;
         s3_ff.mid  <= s3_in.mid;
         s3_ff.hi   <= s3_in.hi;
      end
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_ff.valid <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= col_valid && col_pos.emit;
         s3_ff.valid <= s3_in.valid;
      end
   end

   assign part = s3_ff;

endmodule

>>> rtl/core/median_filter_3x3.sv
`timescale 1ns / 1ps

// 3x3 median filter over a raster-order stream of 8-bit grey pixels. One pixel is
// taken every clock while the result side keeps up, and a stalled result stalls the
// whole pipeline behind the output register. The pipeline runs line-store read, column
// sort, merge of the three sorted columns, and the final median of three. The two rows
// above are held in one MAX_WIDTH-deep memory with 16-bit entries, read and written
// once per pixel, with a forward path when the same column is written and read in the
// same cycle. Pixels on the frame border give no result; tlast marks the median of the
// last interior pixel. Image width and height are clamped to 3..MAX_WIDTH and 3..4096;
// the user must change them only while the block is idle, which the block does not
// enforce. The frame wraps after its last pixel without tuser.
module median_filter_3x3
   import mf3x3_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,  // [7:0] pixel
   input  logic             req_tuser,  // [0] frame_start
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,  // [7:0] median
   output logic             rsp_tlast,
   input  logic             csr_wr_en,
   input  csr_index_type    csr_index,
   input  logic [CFG_W-1:0] csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);

   logic             advance;
   logic             accept;
   logic [CFG_W-1:0] width_ff;
   logic [CFG_W-1:0] height_ff;
   logic [CW-1:0]    rd_addr;
   pos_type          in_pos;
   logic             s1_valid_ff;
   logic [PIX_W-1:0] s1_px_ff;
   logic [CW-1:0]    s1_addr_ff;
   pos_type          s1_pos_ff;
   logic [LINE_W-1:0] line_data;
   med_part_type     part;
   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_median_ff;
   logic [PIX_W-1:0] rsp_median_in;
   logic             rsp_last_ff;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && advance;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   mf3x3_position #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_position (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .frame_start (req_tuser),
      .width_cfg   (width_ff),
      .height_cfg  (height_ff),
      .addr        (rd_addr),
      .pos         (in_pos)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_px_ff   <= req_tdata;
         s1_addr_ff <= rd_addr;
         s1_pos_ff  <= in_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   mf3x3_line_store #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .advance (advance),
      .rd_addr (rd_addr),
      .wr_en   (advance && s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data ({line_data[PIX_W-1:0], s1_px_ff}),
      .rd_data (line_data)
   );

   mf3x3_median u_median (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .col_valid (s1_valid_ff),
      .col_pos   (s1_pos_ff),
      .up_two    (line_data[LINE_W-1:PIX_W]),
      .up_one    (line_data[PIX_W-1:0]),
      .pixel     (s1_px_ff),
      .part      (part)
   );

   assign rsp_median_in = med3(part.lo, part.mid, part.hi);

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_median_ff <= rsp_median_in;
         rsp_last_ff   <= part.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= part.valid;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_median_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> rtl/core/mf3x3_checker.sv
`timescale 1ns / 1ps
`include "median_filter_3x3_defines.svh"

module mf3x3_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   `MF3X3_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "result beat changed while stalled")

   `MF3X3_ASSERT_SAME(a_ready_when_empty, !rsp_tvalid, req_tready, "input stalled with an empty output register")

   `MF3X3_ASSERT_SAME(a_result_has_source, $rose(rsp_tvalid) && $past(!rsp_tvalid, 2) && $past(!rsp_tvalid, 3) && $past(!rsp_tvalid, 4), $past(req_tvalid && req_tready, 4), "result beat without a matching input beat")

endmodule

bind median_filter_3x3 mf3x3_checker u_mf3x3_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import mf3x3_pkg::*;

   localparam int SIZE_MIN     = 3;
   localparam int WIDTH_MAX    = 4096;
   localparam int HEIGHT_MAX   = 4096;
   localparam int SETTLE       = 8;
   localparam int STALL_LIMIT  = 4000;

   typedef struct packed {
      logic [7:0] median;
      logic       last;
   } median_beat_t;

   logic             clock;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata  = '0;
   logic             req_tuser  = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [7:0]       rsp_tdata;
   logic             rsp_tlast;
   logic             csr_wr_en  = 1'b0;
   csr_index_type    csr_index  = CSR_IMAGE_WIDTH;
   logic [CFG_W-1:0] csr_wdata  = '0;

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int errors      = 0;
   int idle_cycles = 0;

   // Shadow copy of the filter state.
   logic [CFG_W-1:0] cfg_width  = WIDTH_RESET;
   logic [CFG_W-1:0] cfg_height = HEIGHT_RESET;
   logic [7:0]       line_one [WIDTH_MAX];
   logic [7:0]       line_two [WIDTH_MAX];
   logic [8:0][7:0]  window_px = '0;
   logic [11:0]      col_pos   = '0;
   logic [11:0]      row_pos   = '0;

   median_beat_t expected_medians[$];
   median_beat_t want;

   median_filter_3x3 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < WIDTH_MAX; i++) begin
         line_one[i] = '0;
         line_two[i] = '0;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v, input int hi);
      if (v < SIZE_MIN) return SIZE_MIN;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [7:0] median_of_nine(input logic [8:0][7:0] taps);
      int below;
      int same;
      for (int i = 0; i < 9; i++) begin
         below = 0;
         same  = 0;
         for (int j = 0; j < 9; j++) begin
            if (taps[j] < taps[i]) below++;
            else if (taps[j] == taps[i]) same++;
         end
         if (below <= 4 && below + same > 4) return taps[i];
      end
      return taps[0];
   endfunction

   function automatic logic [7:0] random_pixel(input int mode);
      case (mode)
         2: return $urandom_range(1) ? 8'hFF : 8'h00;
         3: return 8'(126 + $urandom_range(3));
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic predict_median(input logic [7:0] px, input logic fs);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      logic [7:0]  above_one;
      logic [7:0]  above_two;
      w = clamp_size(cfg_width, WIDTH_MAX);
      h = clamp_size(cfg_height, HEIGHT_MAX);
      if (fs) begin
         col_pos = '0;
         row_pos = '0;
      end
      c = col_pos;
      r = row_pos;
      above_one = '0;
      above_two = '0;
      if (c < WIDTH_MAX) begin
         above_one   = line_one[c];
         above_two   = line_two[c];
         line_two[c] = above_one;
         line_one[c] = px;
      end
      window_px[0] = window_px[1];
      window_px[1] = window_px[2];
      window_px[2] = above_two;
      window_px[3] = window_px[4];
      window_px[4] = window_px[5];
      window_px[5] = above_one;
      window_px[6] = window_px[7];
      window_px[7] = window_px[8];
      window_px[8] = px;
      if (r >= 2 && r < h && c >= 2 && c < w) begin
         expected_medians.push_back('{median_of_nine(window_px),
                                      (r == h - 1) && (c == w - 1)});
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = 12'(c);
      row_pos = 12'(r);
   endtask

   task automatic send_pixel(input logic [7:0] px, input logic fs);
      logic took;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      req_tuser  <= fs;
      do begin
         @(negedge clock);
         took = req_tready;
         if (took) predict_median(px, fs);
         @(posedge clock);
      end while (!took);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_medians.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CFG_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_IMAGE_WIDTH) cfg_width = value;
      else cfg_height = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_list(input logic [7:0] px[$], input logic first_fs);
      for (int i = 0; i < px.size(); i++) send_pixel(px[i], first_fs && i == 0);
   endtask

   task automatic test_default_size();
      for (int i = 0; i < 100; i++) send_pixel(8'($urandom), i == 0);
      wait_idle();
   endtask

   task automatic test_edge_frames();
      write_csr(CSR_IMAGE_WIDTH, 13'd3);
      write_csr(CSR_IMAGE_HEIGHT, 13'd3);
      send_list('{8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255},
                1'b1);
      wait_idle();
      // Sizes below the minimum clamp to 3x3; this frame follows the wrap without a start.
      write_csr(CSR_IMAGE_WIDTH, 13'd0);
      write_csr(CSR_IMAGE_HEIGHT, 13'd2);
      send_list('{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0);
      send_list('{8'd17, 8'd200}, 1'b0);
      send_list('{8'd9, 8'd1, 8'd8, 8'd2, 8'd7, 8'd3, 8'd6, 8'd4, 8'd5}, 1'b1);
      wait_idle();
   endtask

   task automatic test_shrink_mid_row();
      write_csr(CSR_IMAGE_WIDTH, 13'd8);
      write_csr(CSR_IMAGE_HEIGHT, 13'd4);
      for (int i = 0; i < 32 + 13; i++) send_pixel(8'($urandom), i == 0);
      wait_idle();
      // The column counter now sits at the new width.
      write_csr(CSR_IMAGE_WIDTH, 13'd5);
      for (int i = 0; i < 11; i++) send_pixel(8'($urandom), 1'b0);
      wait_idle();
   endtask

   task automatic test_random_frames(input int tx_pct, input int rx_pct, input int n_items);
      int          sent;
      int unsigned eff_w;
      int unsigned eff_h;
      int          rows;
      int          n;
      int          cut;
      int          restart_at;
      int          mode;
      int          pick;
      logic [12:0] w_val;
      logic [12:0] h_val;
      bit          whole;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      sent  = 0;
      whole = 0;
      while (sent < n_items) begin
         if (!whole || $urandom_range(2) == 0) begin
            wait_idle();
            pick  = $urandom_range(9);
            w_val = (pick == 0) ? 13'($urandom_range(2)) : 13'($urandom_range(12, 3));
            pick  = $urandom_range(11);
            if (pick == 0) h_val = 13'($urandom_range(2));
            else if (pick == 1) h_val = 13'($urandom_range(8191, 4097));
            else h_val = 13'($urandom_range(8, 3));
            write_csr(CSR_IMAGE_WIDTH, w_val);
            write_csr(CSR_IMAGE_HEIGHT, h_val);
            whole = 0;
         end
         eff_w = clamp_size(cfg_width, WIDTH_MAX);
         eff_h = clamp_size(cfg_height, HEIGHT_MAX);
         rows  = (eff_h > 8) ? $urandom_range(6, 3) : eff_h;
         n     = eff_w * rows;
         cut   = n;
         if ($urandom_range(7) == 0) cut = $urandom_range(n - 1, 1);
         restart_at = -1;
         if (cut >= 3 && $urandom_range(7) == 0) restart_at = $urandom_range(cut - 1, 1);
         mode = $urandom_range(3);
         for (int i = 0; i < cut; i++) begin
            send_pixel(random_pixel(mode),
                       (i == 0 && (!whole || $urandom_range(3) == 0)) || i == restart_at);
         end
         sent += cut;
         whole = (cut == n) && (restart_at < 0) && (rows == eff_h);
      end
      wait_idle();
   endtask

   task automatic test_max_sizes();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      write_csr(CSR_IMAGE_WIDTH, 13'd8191);
      write_csr(CSR_IMAGE_HEIGHT, 13'd3);
      for (int i = 0; i < 60; i++) send_pixel(8'($urandom), i == 0);
      wait_idle();
      write_csr(CSR_IMAGE_WIDTH, 13'd3);
      write_csr(CSR_IMAGE_HEIGHT, 13'd8191);
      for (int i = 0; i < 60; i++) send_pixel(8'($urandom), i == 0);
      wait_idle();
   endtask

   // Result beats are taken at the next rising edge; values are stable here.
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_medians.size() == 0) begin
            $display("%0t: median %0d last %0b with no result expected",
                     $realtime, rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            want = expected_medians.pop_front();
            if (rsp_tdata !== want.median) begin
               $display("%0t: median expected %0d actual %0d", $realtime, want.median,
                        rsp_tdata);
               errors++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: frame_last expected %0b actual %0b", $realtime, want.last,
                        rsp_tlast);
               errors++;
            end
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else if (req_tvalid || expected_medians.size() != 0) begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      tx_idle_pct = 6;
      rx_idle_pct = 77;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_default_size();
      test_edge_frames();
      test_shrink_mid_row();
      test_random_frames(6, 77, 250);
      test_random_frames(77, 6, 250);
      test_random_frames(0, 0, 250);
      test_max_sizes();
      wait_idle();
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
